// ----- rtl/next_fit_block_allocator_defines.svh -----
// Assertion helpers for the next-fit block allocator.
// Each macro expects clk and rst_n in scope.
`ifndef NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define NEXT_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Check a property at every edge outside reset.
`define NFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition is followed in the next cycle by another.
`define NFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nfba_pkg.sv -----
`default_nettype none

package nfba_pkg;

    // Allocator geometry
    localparam int NUM_BLOCKS  = 4096;
    localparam int DATA_START  = 64;
    localparam int BLK_W       = 12;
    localparam int BND_W       = BLK_W + 1;
    localparam int LIMIT       = (NUM_BLOCKS < 4096) ? NUM_BLOCKS : 4096;

    // Bitmap word layout
    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int NWORDS  = (LIMIT + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    localparam logic [BND_W-1:0] LIMIT_B  = BND_W'(LIMIT);
    localparam logic [BND_W-1:0] DSTART_B = BND_W'(DATA_START);

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [WADDR_W-1:0] waddr_t;
    typedef logic [BND_W-1:0]   bnd_t;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } nfba_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE,
        ST_QUERY,
        ST_EMIT
    } nfba_state_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] idx;
    } nfba_hit_t;

    // Word address of a block number
    function automatic waddr_t word_addr(input bnd_t b);
        return WADDR_W'(b >> BIT_W);
    endfunction

    // Lowest set bit of a candidate word
    function automatic nfba_hit_t first_set(input word_t cand);
        nfba_hit_t hit;
        hit.found = 1'b0;
        hit.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit.found = 1'b1;
                hit.idx   = BIT_W'(i);
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nfba_ram.sv -----
`default_nettype none

module nfba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/next_fit_block_allocator.sv -----
// Next-fit block allocator with a bitmap held in a word-wide RAM.
// Input channel: in_valid / in_stall with kind and target_block; a beat is
// taken when in_valid is high and in_stall is low. The block works on one
// request at a time and raises in_stall until the result is handed to the
// output register.
// Output channel: out_valid / out_stall with granted_block, ok, block_free;
// exactly one result beat per request. The output register holds the beat
// while out_stall is high, and the next request may already be taken then.
// Steps: free and query read the target's bitmap word, then pass through
// ST_FREE or ST_QUERY and ST_EMIT to the output register; a request that
// needs no bitmap read (reserved or out-of-range target, unused kind) goes
// straight to ST_EMIT. An allocate reads one 32-bit bitmap word per cycle
// from the rover onward, wrapping to the data start, then goes to ST_EMIT.
// A new beat can be taken in the same cycle that out_valid rises.
// Reset: every bitmap word reads as all free through per-word valid flops
// cleared at once, so no clearing pass is needed; the rover returns to the
// data start. Blocks below the data start always count as used.
`default_nettype none
`include "next_fit_block_allocator_defines.svh"

module next_fit_block_allocator
    import nfba_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [1:0]       kind,
    input  wire logic [BLK_W-1:0] target_block,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic      [BLK_W-1:0] granted_block,
    output logic                  ok,
    output logic                  block_free
);

    nfba_state_t      state_reg, state_next;
    logic [BLK_W-1:0] rover_reg, rover_next;
    logic             phase_reg, phase_next;
    logic             out_valid_reg, out_valid_next;
    logic [NWORDS-1:0] vld_reg;
    logic             rd_vld_reg;

    bnd_t   tgt_reg, tgt_next;
    bnd_t   start_reg, start_next;
    bnd_t   lo_reg, lo_next;
    bnd_t   hi_reg, hi_next;
    waddr_t scan_w_reg, scan_w_next;

    logic [BLK_W-1:0] res_granted_reg, res_granted_next;
    logic             res_ok_reg, res_ok_next;
    logic             res_free_reg, res_free_next;
    logic [BLK_W-1:0] granted_reg, granted_next;
    logic             ok_reg, ok_next;
    logic             free_reg, free_next;

    logic   ram_re;
    waddr_t ram_raddr;
    logic   ram_we;
    waddr_t ram_waddr;
    word_t  ram_wdata;
    word_t  ram_rdata;

    word_t     rd_word;
    word_t     scan_mask;
    word_t     cand;
    nfba_hit_t hit;
    logic      lo_hit;
    logic      hi_hit;
    bnd_t      end_b;
    bnd_t      found_blk;
    bnd_t      after_blk;
    bnd_t      start_blk;
    logic      accept;

    nfba_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (NWORDS),
        .ADDR_W (WADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and port drive
    assign in_stall      = (state_reg != ST_IDLE);
    assign accept        = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign granted_block = granted_reg;
    assign ok            = ok_reg;
    assign block_free    = free_reg;

    // Treat never-written words as all free
    assign rd_word = rd_vld_reg ? ram_rdata : '0;

    // Normalized scan start from the rover
    assign start_blk = (BND_W'(rover_reg) < DSTART_B || BND_W'(rover_reg) >= LIMIT_B)
                       ? DSTART_B : BND_W'(rover_reg);

    // Mask the current word to the scan bounds and pick the first free bit
    always_comb
    begin
        end_b  = hi_reg - 1'b1;
        lo_hit = (scan_w_reg == word_addr(lo_reg));
        hi_hit = (scan_w_reg == word_addr(end_b));
        for (int i = 0; i < WORD_W; i++)
        begin
            scan_mask[i] = (!lo_hit || BIT_W'(i) >= lo_reg[BIT_W-1:0])
                        && (!hi_hit || BIT_W'(i) <= end_b[BIT_W-1:0]);
        end
        cand      = ~rd_word & scan_mask;
        hit       = first_set(cand);
        found_blk = (BND_W'(scan_w_reg) << BIT_W) | BND_W'(hit.idx);
        after_blk = found_blk + 1'b1;
        if (after_blk >= LIMIT_B)
        begin
            after_blk = DSTART_B;
        end
    end

    // Next state, RAM access and results
    always_comb
    begin
        state_next       = state_reg;
        rover_next       = rover_reg;
        phase_next       = phase_reg;
        tgt_next         = tgt_reg;
        start_next       = start_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        scan_w_next      = scan_w_reg;
        res_granted_next = res_granted_reg;
        res_ok_next      = res_ok_reg;
        res_free_next    = res_free_reg;
        granted_next     = granted_reg;
        ok_next          = ok_reg;
        free_next        = free_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ram_re           = 1'b0;
        ram_raddr        = scan_w_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_w_reg;
        ram_wdata        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    tgt_next         = BND_W'(target_block);
                    res_granted_next = '0;
                    res_ok_next      = 1'b0;
                    res_free_next    = 1'b0;
                    state_next       = ST_EMIT;
                    case (kind)
                        KIND_ALLOC:
                        begin
                            if (DSTART_B < LIMIT_B)
                            begin
                                start_next  = start_blk;
                                lo_next     = start_blk;
                                hi_next     = LIMIT_B;
                                phase_next  = 1'b0;
                                scan_w_next = word_addr(start_blk);
                                ram_re      = 1'b1;
                                ram_raddr   = word_addr(start_blk);
                                state_next  = ST_SCAN;
                            end
                        end
                        KIND_FREE:
                        begin
                            if (BND_W'(target_block) >= DSTART_B
                                && BND_W'(target_block) < LIMIT_B)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = word_addr(BND_W'(target_block));
                                state_next = ST_FREE;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (BND_W'(target_block) < LIMIT_B)
                            begin
                                if (BND_W'(target_block) < DSTART_B)
                                begin
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = word_addr(BND_W'(target_block));
                                    state_next = ST_QUERY;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit.found)
                begin
                    // Mark the block used and advance the rover
                    ram_we           = 1'b1;
                    ram_waddr        = scan_w_reg;
                    ram_wdata        = rd_word | (word_t'(1) << hit.idx);
                    rover_next       = BLK_W'(after_blk);
                    res_granted_next = BLK_W'(found_blk);
                    res_ok_next      = 1'b1;
                    state_next       = ST_EMIT;
                end
                else if (hi_hit)
                begin
                    if (!phase_reg && start_reg != DSTART_B)
                    begin
                        // Wrap to the data start, stop short of the rover
                        phase_next  = 1'b1;
                        lo_next     = DSTART_B;
                        hi_next     = start_reg;
                        scan_w_next = word_addr(DSTART_B);
                        ram_re      = 1'b1;
                        ram_raddr   = word_addr(DSTART_B);
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    scan_w_next = scan_w_reg + 1'b1;
                    ram_re      = 1'b1;
                    ram_raddr   = scan_w_reg + 1'b1;
                end
            end

            ST_FREE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = word_addr(tgt_reg);
                ram_wdata   = rd_word & ~(word_t'(1) << tgt_reg[BIT_W-1:0]);
                res_ok_next = 1'b1;
                state_next  = ST_EMIT;
            end

            ST_QUERY:
            begin
                res_ok_next   = 1'b1;
                res_free_next = ~rd_word[tgt_reg[BIT_W-1:0]];
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    granted_next   = res_granted_reg;
                    ok_next        = res_ok_reg;
                    free_next      = res_free_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rover_reg     <= BLK_W'(DATA_START);
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (ram_we)
            begin
                vld_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[ram_raddr];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tgt_reg         <= tgt_next;
        start_reg       <= start_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        scan_w_reg      <= scan_w_next;
        res_granted_reg <= res_granted_next;
        res_ok_reg      <= res_ok_next;
        res_free_reg    <= res_free_next;
        granted_reg     <= granted_next;
        ok_reg          <= ok_next;
        free_reg        <= free_next;
    end

    // Assertions
    `NFBA_ASSERT(a_fail_beat_clean,
        (out_valid && !ok) |-> (granted_block == '0 && !block_free),
        "failed beat carries data")
    `NFBA_ASSERT(a_grant_in_data,
        (out_valid && granted_block != '0)
            |-> (BND_W'(granted_block) >= DSTART_B && BND_W'(granted_block) < LIMIT_B),
        "grant outside data region")
    `NFBA_ASSERT(a_rover_range,
        (BND_W'(rover_reg) >= DSTART_B && BND_W'(rover_reg) < LIMIT_B)
            || rover_reg == BLK_W'(DATA_START),
        "rover outside data region")
    `NFBA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state_reg != ST_IDLE,
        "request beat not taken up")

endmodule

`default_nettype wire

// ----- tb/tb_next_fit_block_allocator.sv -----
`timescale 1ns / 1ps

module tb_next_fit_block_allocator;
    import nfba_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;

    typedef struct packed {
        logic [BLK_W-1:0] granted;
        logic             ok;
        logic             free_bit;
    } reply_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    nfba_kind_t       kind = KIND_ALLOC;
    logic [BLK_W-1:0] target_block = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [BLK_W-1:0] granted_block;
    logic             ok;
    logic             block_free;

    // Allocator state as the requests should leave it
    bit     used_bits [LIMIT];
    int     rover_pos;
    reply_t pending_replies[$];
    int     owned_q[$];

    bit     calm = 1'b0;
    int     stall_hold = 0;
    int     cycle_cnt = 0;
    int     err_cnt = 0;
    int     beat_cnt = 0;
    int     n_grant = 0;
    int     n_nospace = 0;
    int     n_free = 0;
    int     n_query = 0;
    int     n_sent = 0;
    reply_t want_reply;

    next_fit_block_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .target_block  (target_block),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_block (granted_block),
        .ok            (ok),
        .block_free    (block_free)
    );

    always #4 clk = ~clk;

    // Bring the map and the rover to their reset values
    function automatic void clear_map();
        for (int i = 0; i < LIMIT; i++)
        begin
            used_bits[i] = (i < DATA_START);
        end
        rover_pos = DATA_START;
    endfunction

    // Apply one request to the map and work out its reply
    function automatic reply_t serve_request(input nfba_kind_t k, input logic [BLK_W-1:0] t);
        reply_t r;
        int     b;
        r = '0;
        case (k)
            KIND_ALLOC:
            begin
                if (DATA_START < LIMIT)
                begin
                    b = rover_pos;
                    if (b < DATA_START || b >= LIMIT)
                        b = DATA_START;
                    for (int i = 0; i < LIMIT - DATA_START; i++)
                    begin
                        if (!used_bits[b])
                        begin
                            used_bits[b] = 1'b1;
                            r.granted    = BLK_W'(b);
                            r.ok         = 1'b1;
                            rover_pos    = (b + 1 >= LIMIT) ? DATA_START : b + 1;
                            break;
                        end
                        b = (b + 1 >= LIMIT) ? DATA_START : b + 1;
                    end
                end
            end
            KIND_FREE:
            begin
                if (int'(t) >= DATA_START && int'(t) < LIMIT)
                begin
                    used_bits[t] = 1'b0;
                    r.ok         = 1'b1;
                end
            end
            KIND_QUERY:
            begin
                if (int'(t) < LIMIT)
                begin
                    r.ok       = 1'b1;
                    r.free_bit = !used_bits[t];
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    // Pick an idle gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 45)
            return 0;
        else if (p < 85)
            return $urandom_range(1, 3);
        else if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Send one request beat, hold it until taken, then record its reply
    task automatic issue(input nfba_kind_t k, input logic [BLK_W-1:0] t, output reply_t r);
        int gap;
        in_valid     <= 1'b1;
        kind         <= k;
        target_block <= t;
        do
            @(posedge clk);
        while (in_stall);
        r = serve_request(k, t);
        pending_replies.push_back(r);
        n_sent++;
        case (k)
            KIND_ALLOC:
            begin
                if (r.ok)
                begin
                    n_grant++;
                    owned_q.push_back(int'(r.granted));
                end
                else
                    n_nospace++;
            end
            KIND_FREE:  n_free++;
            KIND_QUERY: n_query++;
            default:    ;
        endcase
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Extremes of the block number, every kind, reserved and double frees
    task automatic test_directed();
        reply_t r;
        issue(KIND_QUERY, '0, r);
        issue(KIND_QUERY, BLK_W'(DATA_START - 1), r);
        issue(KIND_QUERY, BLK_W'(DATA_START), r);
        issue(KIND_QUERY, '1, r);
        issue(KIND_FREE, '0, r);
        issue(KIND_FREE, BLK_W'(DATA_START - 1), r);
        issue(KIND_FREE, BLK_W'(DATA_START), r);
        issue(KIND_NONE, '0, r);
        issue(KIND_NONE, '1, r);
        issue(KIND_ALLOC, '1, r);
        issue(KIND_ALLOC, '0, r);
        issue(KIND_ALLOC, 12'hAAA, r);
        issue(KIND_QUERY, BLK_W'(DATA_START + 1), r);
        issue(KIND_FREE, BLK_W'(DATA_START + 1), r);
        issue(KIND_QUERY, BLK_W'(DATA_START + 1), r);
        issue(KIND_ALLOC, 12'h555, r);
        issue(KIND_FREE, '1, r);
        issue(KIND_FREE, 12'hAAA, r);
        issue(KIND_QUERY, 12'h555, r);
        issue(KIND_FREE, BLK_W'(DATA_START + 1), r);
        issue(KIND_NONE, 12'h555, r);
    endtask

    // Random mix of allocate, free, query and unused kinds
    task automatic test_random_mix(input int count);
        reply_t           r;
        int               pick;
        int               sel;
        int               idx;
        logic [BLK_W-1:0] t;
        for (int n = 0; n < count; n++)
        begin
            // Quiet stretch at the start of every 200 beats
            calm <= ((n % 200) < 30);
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            if (pick < 42)
                issue(KIND_ALLOC, BLK_W'($urandom), r);
            else if (pick < 77)
            begin
                if (sel < 6 && owned_q.size() != 0)
                begin
                    idx = $urandom_range(0, owned_q.size() - 1);
                    t   = BLK_W'(owned_q[idx]);
                    owned_q.delete(idx);
                end
                else if (sel < 9)
                    t = BLK_W'($urandom_range(DATA_START, LIMIT - 1));
                else
                    t = BLK_W'($urandom);
                issue(KIND_FREE, t, r);
            end
            else if (pick < 95)
            begin
                if (sel < 5 && owned_q.size() != 0)
                    t = BLK_W'(owned_q[$urandom_range(0, owned_q.size() - 1)]);
                else
                    t = BLK_W'($urandom);
                issue(KIND_QUERY, t, r);
            end
            else
                issue(KIND_NONE, BLK_W'($urandom), r);
        end
        calm <= 1'b0;
    endtask

    // Burst of allocates, then free blocks behind the rover: next fit skips them
    task automatic test_next_fit();
        reply_t           r;
        logic [BLK_W-1:0] behind;
        calm <= 1'b1;
        repeat (24)
            issue(KIND_ALLOC, BLK_W'($urandom), r);
        calm <= 1'b0;
        behind = (rover_pos == DATA_START) ? BLK_W'(LIMIT - 1) : BLK_W'(rover_pos - 1);
        issue(KIND_FREE, behind, r);
        issue(KIND_FREE, BLK_W'(DATA_START), r);
        issue(KIND_QUERY, behind, r);
        issue(KIND_ALLOC, '0, r);
        issue(KIND_ALLOC, '0, r);
        issue(KIND_QUERY, behind, r);
        issue(KIND_QUERY, '1, r);
    endtask

    // Stall the result side at random, in short and long runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_hold <= 0;
        end
        else if (stall_hold != 0)
            stall_hold <= stall_hold - 1;
        else if (calm)
            out_stall <= 1'b0;
        else
        begin
            case ($urandom_range(0, 19))
                0:       begin out_stall <= 1'b1; stall_hold <= $urandom_range(10, 40); end
                1, 2, 3,
                4, 5:    begin out_stall <= 1'b1; stall_hold <= $urandom_range(0, 3); end
                default: begin out_stall <= 1'b0; stall_hold <= $urandom_range(0, 3); end
            endcase
        end
    end

    // Compare each result beat against the oldest outstanding reply
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            beat_cnt++;
            if (pending_replies.size() == 0)
            begin
                $error("result beat with no request outstanding");
                err_cnt++;
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                if (granted_block !== want_reply.granted)
                begin
                    $error("granted_block: expected %0d, got %0d", want_reply.granted,
                           granted_block);
                    err_cnt++;
                end
                if (ok !== want_reply.ok)
                begin
                    $error("ok: expected %0d, got %0d", want_reply.ok, ok);
                    err_cnt++;
                end
                if (block_free !== want_reply.free_bit)
                begin
                    $error("block_free: expected %0d, got %0d", want_reply.free_bit,
                           block_free);
                    err_cnt++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clear_map();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(680);
        test_next_fit();
        test_random_mix(680);

        // Drain the outstanding replies, then let the pipeline settle
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d requests: %0d grants, %0d failed allocates, %0d frees, %0d queries",
                 n_sent, n_grant, n_nospace, n_free, n_query);
        $display("Checked %0d result beats with random gaps and stalls on both sides", beat_cnt);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/nfba_pkg.sv
rtl/nfba_ram.sv
rtl/next_fit_block_allocator.sv
tb/tb_next_fit_block_allocator.sv
